// File: src/pfd_pkg.sv
// Package for the Playfair pair decryptor: sizes, command and status codes,
// the cell position type and the letter and cell address helper functions.
// Depends on nothing; every other file of the block but pfd_ram uses it.
`default_nettype none

package pfd_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;
    localparam int CELL_W  = $clog2(LETTERS);
    localparam int COORD_W = 3;
    localparam int COUNT_W = $clog2(CELLS + 1);

    localparam logic [CELL_W-1:0] IDX_Q = CELL_W'(16);
    localparam logic [CELL_W-1:0] IDX_K = CELL_W'(10);
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5A;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_KEY      = 2'd1,
        CMD_COMPLETE = 2'd2,
        CMD_DECRYPT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NOT_FOUND    = 2'd1,
        STATUS_NOT_COMPLETE = 2'd2
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] idx;
    } letter_t;

    // Upper case letter to its index, with Q taken as K.
    function automatic letter_t cipher_letter(input logic [7:0] ch);
        letter_t    res;
        logic [7:0] diff;
        diff    = ch - CHAR_UA;
        res.ok  = (ch >= CHAR_UA) && (ch <= CHAR_UZ);
        res.idx = diff[CELL_W-1:0];
        if (res.idx == IDX_Q)
        begin
            res.idx = IDX_K;
        end
        return res;
    endfunction

    // Key bytes are folded to upper case before the lookup.
    function automatic letter_t key_letter(input logic [7:0] ch);
        logic [7:0] up;
        up = ch;
        if ((ch >= CHAR_LA) && (ch <= CHAR_LZ))
        begin
            up = ch - CASE_GAP;
        end
        return cipher_letter(up);
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input pos_t p);
        return CELL_W'({2'b00, p.row} << 2) + CELL_W'(p.row) + CELL_W'(p.col);
    endfunction

endpackage

`default_nettype wire

// File: src/pfd_req_if.sv
// Request channel of the Playfair pair decryptor: valid, ready and one command item.
// Depends on pfd_pkg for the command type.
`default_nettype none

interface pfd_req_if;
    logic               valid;
    logic               ready;
    pfd_pkg::cmd_t      command;
    logic [7:0]         key_char;
    logic [7:0]         cipher_first;
    logic [7:0]         cipher_second;

    modport source (output valid, command, key_char, cipher_first, cipher_second,
                    input ready);
    modport sink (input valid, command, key_char, cipher_first, cipher_second,
                  output ready);
endinterface

`default_nettype wire

// File: src/pfd_rsp_if.sv
// Result channel of the Playfair pair decryptor: valid, ready and one decrypted pair.
// Depends on pfd_pkg for the status type.
`default_nettype none

interface pfd_rsp_if;
    logic               valid;
    logic               ready;
    logic [6:0]         plain_first;
    logic [6:0]         plain_second;
    pfd_pkg::status_t   status;

    modport source (output valid, plain_first, plain_second, status, input ready);
    modport sink (input valid, plain_first, plain_second, status, output ready);
endinterface

`default_nettype wire

// File: src/pfd_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
`default_nettype none

module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// File: src/pfd_pair_map.sv
// Playfair decryption rule: maps the two cipher positions to the two plaintext cells.
// Depends on pfd_pkg for the position type and the cell address function.
`default_nettype none

module pfd_pair_map (
    input  wire pfd_pkg::pos_t                 pos_first,
    input  wire pfd_pkg::pos_t                 pos_second,
    output logic [pfd_pkg::CELL_W-1:0]         cell_first,
    output logic [pfd_pkg::CELL_W-1:0]         cell_second
);
    import pfd_pkg::*;

    localparam logic [COORD_W-1:0] LAST = COORD_W'(SIDE - 1);

    pos_t out_first;
    pos_t out_second;

    function automatic logic [COORD_W-1:0] step_back(input logic [COORD_W-1:0] v);
        return (v == '0) ? LAST : v - COORD_W'(1);
    endfunction

    always_comb
    begin
        out_first  = pos_first;
        out_second = pos_second;
        priority if (pos_first.row == pos_second.row)
        begin
            out_first.col  = step_back(pos_first.col);
            out_second.col = step_back(pos_second.col);
        end
        else if (pos_first.col == pos_second.col)
        begin
            out_first.row  = step_back(pos_first.row);
            out_second.row = step_back(pos_second.row);
        end
        else
        begin
            out_first.col  = pos_second.col;
            out_second.col = pos_first.col;
        end
    end

    assign cell_first  = cell_addr(out_first);
    assign cell_second = cell_addr(out_second);

endmodule

`default_nettype wire

// File: src/playfair_pair_decrypt_core.sv
// Top level of the Playfair pair decryptor: command sequencer, square state and result register.
// Depends on pfd_pkg, pfd_req_if, pfd_rsp_if, pfd_ram and pfd_pair_map.
`default_nettype none

// Clear and key commands are worked as they are accepted. Complete, on a square not yet
// complete, walks the alphabet letter by letter, writing at most one cell a cycle.
// A decrypt reads the two letter positions, then the two plaintext cells, both through
// two-port memories, then loads the result register. Decrypts that fail a check give
// their result in the cycle after acceptance. The block takes one item at a time, and
// a new item only once the result register is free or is being emptied.
module playfair_pair_decrypt_core (
    input  wire logic clk,
    input  wire logic rst_n,
    pfd_req_if.sink   req,
    pfd_rsp_if.source rsp
);
    import pfd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_POS, ST_CELL} state_t;

    state_t              state_reg, state_next;
    logic [LETTERS-1:0]  used_reg, used_next;
    logic [COUNT_W-1:0]  fill_count_reg, fill_count_next;
    pos_t                fill_pos_reg, fill_pos_next;
    logic                complete_reg, complete_next;
    logic [CELL_W-1:0]   walk_reg, walk_next;
    logic                out_valid_reg, out_valid_next;
    logic [6:0]          plain_first_reg, plain_first_next;
    logic [6:0]          plain_second_reg, plain_second_next;
    status_t             status_reg, status_next;

    logic                accept;
    logic                put;
    logic [CELL_W-1:0]   put_idx;
    letter_t             key_l;
    letter_t             first_l;
    letter_t             second_l;
    pos_t                pos_first;
    pos_t                pos_second;
    logic [CELL_W-1:0]   cell_first;
    logic [CELL_W-1:0]   cell_second;
    logic [CELL_W-1:0]   val_first;
    logic [CELL_W-1:0]   val_second;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign key_l    = key_letter(req.key_char);
    assign first_l  = cipher_letter(req.cipher_first);
    assign second_l = cipher_letter(req.cipher_second);

    pfd_ram #(
        .WIDTH ($bits(pos_t)),
        .DEPTH (LETTERS)
    ) u_pos_ram (
        .clk       (clk),
        .wr_en     (put),
        .wr_addr   (put_idx),
        .wr_data   (fill_pos_reg),
        .rd_addr_a (first_l.idx),
        .rd_addr_b (second_l.idx),
        .rd_data_a (pos_first),
        .rd_data_b (pos_second)
    );

    pfd_pair_map u_map (
        .pos_first   (pos_first),
        .pos_second  (pos_second),
        .cell_first  (cell_first),
        .cell_second (cell_second)
    );

    pfd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk       (clk),
        .wr_en     (put),
        .wr_addr   (fill_count_reg[CELL_W-1:0]),
        .wr_data   (put_idx),
        .rd_addr_a (cell_first),
        .rd_addr_b (cell_second),
        .rd_data_a (val_first),
        .rd_data_b (val_second)
    );

    always_comb
    begin
        put     = 1'b0;
        put_idx = key_l.idx;
        unique case (state_reg)
            ST_IDLE:
            begin
                put = accept && (req.command == CMD_KEY) && !complete_reg && key_l.ok
                      && !used_reg[key_l.idx] && (fill_count_reg < COUNT_W'(CELLS));
            end
            ST_FILL:
            begin
                put_idx = walk_reg;
                put     = (walk_reg != IDX_Q) && !used_reg[walk_reg]
                          && (fill_count_reg < COUNT_W'(CELLS));
            end
            default:
            begin
                put = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        fill_count_next   = fill_count_reg;
        fill_pos_next     = fill_pos_reg;
        complete_next     = complete_reg;
        walk_next         = walk_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        plain_first_next  = plain_first_reg;
        plain_second_next = plain_second_reg;
        status_next       = status_reg;

        if (put)
        begin
            used_next[put_idx] = 1'b1;
            fill_count_next    = fill_count_reg + COUNT_W'(1);
            if (fill_pos_reg.col == COORD_W'(SIDE - 1))
            begin
                fill_pos_next.col = '0;
                fill_pos_next.row = fill_pos_reg.row + COORD_W'(1);
            end
            else
            begin
                fill_pos_next.col = fill_pos_reg.col + COORD_W'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.command)
                        CMD_CLEAR:
                        begin
                            used_next       = '0;
                            fill_count_next = '0;
                            fill_pos_next   = '0;
                            complete_next   = 1'b0;
                        end
                        CMD_KEY:
                        begin
                        end
                        CMD_COMPLETE:
                        begin
                            if (!complete_reg)
                            begin
                                walk_next  = '0;
                                state_next = ST_FILL;
                            end
                        end
                        CMD_DECRYPT:
                        begin
                            plain_first_next  = '0;
                            plain_second_next = '0;
                            if (!complete_reg)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STATUS_NOT_COMPLETE;
                            end
                            else if (!(first_l.ok && second_l.ok && used_reg[first_l.idx]
                                       && used_reg[second_l.idx]))
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = ST_POS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (walk_reg == CELL_W'(LETTERS - 1))
                begin
                    complete_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + CELL_W'(1);
                end
            end
            ST_POS:
            begin
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                out_valid_next    = 1'b1;
                status_next       = STATUS_OK;
                plain_first_next  = 7'(CHAR_UA) + 7'(val_first);
                plain_second_next = 7'(CHAR_UA) + 7'(val_second);
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            used_reg         <= '0;
            fill_count_reg   <= '0;
            fill_pos_reg     <= '0;
            complete_reg     <= 1'b0;
            walk_reg         <= '0;
            out_valid_reg    <= 1'b0;
            plain_first_reg  <= '0;
            plain_second_reg <= '0;
            status_reg       <= STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            fill_count_reg   <= fill_count_next;
            fill_pos_reg     <= fill_pos_next;
            complete_reg     <= complete_next;
            walk_reg         <= walk_next;
            out_valid_reg    <= out_valid_next;
            plain_first_reg  <= plain_first_next;
            plain_second_reg <= plain_second_next;
            status_reg       <= status_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.plain_first  = plain_first_reg;
    assign rsp.plain_second = plain_second_reg;
    assign rsp.status       = status_reg;

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= COUNT_W'(CELLS))
        else $error("Fill count runs past the end of the square.");

    a_complete_full : assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> (fill_count_reg == COUNT_W'(CELLS)))
        else $error("Square marked complete while cells are still empty.");

    a_result_slot_free : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> !out_valid_reg)
        else $error("A decrypted pair would overwrite a result still waiting.");

    a_ok_is_letter : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_OK)) |->
            ((plain_first_reg >= 7'(CHAR_UA)) && (plain_second_reg >= 7'(CHAR_UA))))
        else $error("A good result carries a character that is not a letter.");

    a_busy_not_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("Item taken while a command is still being worked.");

endmodule

`default_nettype wire
